// ----- rtl/peer_liveness_loss_tracker_assert.svh -----
// Assertion macros for the peer liveness tracker.
// Needs clk_i and rst_ni in the scope that uses them.
`ifndef PEER_LIVENESS_LOSS_TRACKER_ASSERT_SVH
`define PEER_LIVENESS_LOSS_TRACKER_ASSERT_SVH

// Same-cycle implication, off during reset.
`define PLLT_ASSERT_IMP(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, off during reset.
`define PLLT_ASSERT_NXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ----- rtl/pllt_pkg.sv -----
// Package for the peer liveness tracker: sizes, reset values, codes.
// Used by pllt_alu and peer_liveness_loss_tracker; no dependencies.
`timescale 1ns / 1ps

package pllt_pkg;

  localparam int Nodes  = 8;
  localparam int NodeW  = (Nodes > 1) ? $clog2(Nodes) : 1;
  localparam int WordW  = 32;
  localparam int TimerW = 16;
  localparam int SelfW  = 3;
  localparam int IdW    = 3;
  localparam int CfgW   = 16;
  localparam int MaskW  = 8;

  localparam logic [SelfW-1:0]  SelfNodeRst    = '0;
  localparam logic [TimerW-1:0] AliveReloadRst = 16'd8000;

  typedef enum logic [0:0] {
    CfgSelfNode    = 1'b0,
    CfgAliveReload = 1'b1
  } cfg_idx_e;

  // shared adder control
  typedef struct packed {
    logic invert_b;
    logic carry_in;
  } alu_ctl_t;

endpackage

// ----- rtl/pllt_alu.sv -----
// Shared 32-bit add/subtract unit of the peer liveness tracker.
// Depends on pllt_pkg.
`timescale 1ns / 1ps

module pllt_alu (
  input  logic [pllt_pkg::WordW-1:0] a_i,
  input  logic [pllt_pkg::WordW-1:0] b_i,
  input  pllt_pkg::alu_ctl_t         ctl_i,
  output logic [pllt_pkg::WordW-1:0] sum_o,
  output logic                       carry_o
);

  logic [pllt_pkg::WordW-1:0] b_op;

  assign b_op = ctl_i.invert_b ? ~b_i : b_i;

  // carry out doubles as "no borrow" when subtracting
  assign {carry_o, sum_o} = {1'b0, a_i} + {1'b0, b_op}
                          + (pllt_pkg::WordW + 1)'(ctl_i.carry_in);

endmodule

// ----- rtl/peer_liveness_loss_tracker.sv -----
// Peer liveness tracker top level: sequencer, node tables, result registers.
// Depends on pllt_pkg, pllt_alu and peer_liveness_loss_tracker_assert.svh.
`timescale 1ns / 1ps
//
// Usage
// - Command channel: an item is taken on a clock edge with start_i high and
//   busy_o low. operation_i = 1 is a packet from node_i with
//   sequence_number_i; operation_i = 0 is a time tick at now_ms_i.
// - Result channel: done_o pulses for one cycle; alive_mask_o, lost_mask_o,
//   loss_count_o and receive_count_o are valid in that cycle. lost_mask_o and
//   the counts hold until the next result, alive_mask_o follows the timers.
//   There is no back-pressure: the receiver takes the result then.
// - Sequencing: a packet runs the gap, loss update and receive count steps,
//   each one pass through the shared adder. A tick computes the elapsed
//   time and, when a previous time is stored, then walks the node timers
//   one per cycle through the same adder.
// - Hand-off: busy_o stays high until done_o rises; start_i is taken again
//   in the done_o cycle, so a new item is taken only after the last is done.
// - Config: cfg_we_i writes self node (index 0) or alive reload (index 1)
//   at once; write only while idle.
// - Reset: all counters and sequences clear, node 0 timer holds the reload
//   reset value, previous time is zero.
module peer_liveness_loss_tracker (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  // config port
  input  logic                                cfg_we_i,
  input  logic [0:0]                          cfg_idx_i,
  input  logic [pllt_pkg::CfgW-1:0]           cfg_data_i,
  // command
  input  logic                                start_i,
  output logic                                busy_o,
  input  logic                                operation_i,
  input  logic [pllt_pkg::IdW-1:0]            node_i,
  input  logic [pllt_pkg::WordW-1:0]          sequence_number_i,
  input  logic [pllt_pkg::WordW-1:0]          now_ms_i,
  // result
  output logic                                done_o,
  output logic [pllt_pkg::MaskW-1:0]          alive_mask_o,
  output logic [pllt_pkg::MaskW-1:0]          lost_mask_o,
  output logic [pllt_pkg::WordW-1:0]          loss_count_o,
  output logic [pllt_pkg::WordW-1:0]          receive_count_o
);

  typedef enum logic [5:0] {
    StIdle    = 6'b000001,
    StGap     = 6'b000010,
    StLoss    = 6'b000100,
    StSeen    = 6'b001000,
    StElapsed = 6'b010000,
    StWalk    = 6'b100000
  } state_e;

  state_e state_q, state_d;

  // config registers
  logic [pllt_pkg::SelfW-1:0]  self_q;
  logic [pllt_pkg::TimerW-1:0] reload_q;

  // latched item
  logic [pllt_pkg::IdW-1:0]    node_q;
  logic [pllt_pkg::WordW-1:0]  seq_q;
  logic [pllt_pkg::WordW-1:0]  now_q;

  // node tables
  logic [pllt_pkg::WordW-1:0]  last_seq_q [pllt_pkg::Nodes];
  logic [pllt_pkg::WordW-1:0]  lost_q     [pllt_pkg::Nodes];
  logic [pllt_pkg::WordW-1:0]  seen_q     [pllt_pkg::Nodes];
  logic [pllt_pkg::TimerW-1:0] timer_q    [pllt_pkg::Nodes];
  logic [pllt_pkg::Nodes-1:0]  alive_q;
  logic [pllt_pkg::WordW-1:0]  prev_q;

  // working registers
  logic [pllt_pkg::WordW-1:0]  gap_q;    // also holds elapsed time on ticks
  logic [pllt_pkg::NodeW-1:0]  idx_q;
  logic [pllt_pkg::MaskW-1:0]  lost_acc_q;

  // result registers
  logic                        done_q;
  logic [pllt_pkg::MaskW-1:0]  lost_mask_q;
  logic [pllt_pkg::WordW-1:0]  loss_out_q;
  logic [pllt_pkg::WordW-1:0]  recv_out_q;

  logic                        accept;
  logic                        node_ok;
  logic [pllt_pkg::NodeW-1:0]  addr;
  logic                        last_idx;
  logic                        skip_self;
  logic [pllt_pkg::TimerW-1:0] timer_rd;
  logic [pllt_pkg::WordW-1:0]  alu_a, alu_b, alu_sum;
  logic                        alu_carry;
  pllt_pkg::alu_ctl_t          alu_ctl;
  logic [pllt_pkg::WordW-1:0]  lost_new;
  logic [pllt_pkg::TimerW-1:0] timer_new;
  logic [pllt_pkg::MaskW-1:0]  lost_bit;

  assign accept    = start_i && (state_q == StIdle);
  assign busy_o    = (state_q != StIdle);
  assign node_ok   = 32'(node_q) < pllt_pkg::Nodes;
  assign addr      = (state_q == StWalk) ? idx_q : pllt_pkg::NodeW'(node_q);
  assign last_idx  = (idx_q == pllt_pkg::NodeW'(pllt_pkg::Nodes - 1));
  assign skip_self = (32'(idx_q) == 32'(self_q));
  assign timer_rd  = timer_q[addr];
  // nodes past the mask width shift out to zero
  assign lost_bit  = pllt_pkg::MaskW'(1) << idx_q;

  // operand select for the shared adder
  always_comb begin
    alu_a   = '0;
    alu_b   = '0;
    alu_ctl = '{invert_b: 1'b0, carry_in: 1'b0};
    unique case (state_q)
      StGap: begin      // seq - last - 1
        alu_a   = seq_q;
        alu_b   = last_seq_q[addr];
        alu_ctl = '{invert_b: 1'b1, carry_in: 1'b0};
      end
      StLoss: begin     // lost + gap
        alu_a = lost_q[addr];
        alu_b = gap_q;
      end
      StSeen: begin     // seen + 1
        alu_a   = seen_q[addr];
        alu_ctl = '{invert_b: 1'b0, carry_in: 1'b1};
      end
      StElapsed: begin  // now - prev
        alu_a   = now_q;
        alu_b   = prev_q;
        alu_ctl = '{invert_b: 1'b1, carry_in: 1'b1};
      end
      StWalk: begin     // timer - elapsed, carry set when no borrow
        alu_a   = {{(pllt_pkg::WordW - pllt_pkg::TimerW){1'b0}}, timer_rd};
        alu_b   = gap_q;
        alu_ctl = '{invert_b: 1'b1, carry_in: 1'b1};
      end
      default: ;
    endcase
  end

  pllt_alu u_alu (
    .a_i    (alu_a),
    .b_i    (alu_b),
    .ctl_i  (alu_ctl),
    .sum_o  (alu_sum),
    .carry_o(alu_carry)
  );

  // loss count update: held while no sequence is stored; negative gap restarts, else saturating add
  always_comb begin
    lost_new = lost_q[addr];
    if (last_seq_q[addr] != '0) begin
      if (gap_q[pllt_pkg::WordW-1]) begin
        lost_new = '0;
      end else if (alu_carry) begin
        lost_new = '1;
      end else begin
        lost_new = alu_sum;
      end
    end
  end

  assign timer_new = alu_carry ? alu_sum[pllt_pkg::TimerW-1:0] : '0;

  always_comb begin
    state_d = state_q;
    unique case (state_q)
      StIdle: begin
        if (start_i) begin
          state_d = operation_i ? StGap : StElapsed;
        end
      end
      StGap:     state_d = node_ok ? StLoss : StIdle;
      StLoss:    state_d = StSeen;
      StSeen:    state_d = StIdle;
      StElapsed: state_d = (prev_q == '0) ? StIdle : StWalk;
      StWalk:    state_d = last_idx ? StIdle : StWalk;
      default:   state_d = StIdle;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= StIdle;
    end else begin
      state_q <= state_d;
    end
  end

  // config writes
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      self_q   <= pllt_pkg::SelfNodeRst;
      reload_q <= pllt_pkg::AliveReloadRst;
    end else if (cfg_we_i) begin
      unique case (pllt_pkg::cfg_idx_e'(cfg_idx_i))
        pllt_pkg::CfgSelfNode:    self_q   <= cfg_data_i[pllt_pkg::SelfW-1:0];
        pllt_pkg::CfgAliveReload: reload_q <= cfg_data_i[pllt_pkg::TimerW-1:0];
        default: ;
      endcase
    end
  end

  // item latch and working registers
  always_ff @(posedge clk_i) begin
    if (accept) begin
      node_q <= node_i;
      seq_q  <= sequence_number_i;
      now_q  <= now_ms_i;
    end
    if (state_q == StGap || state_q == StElapsed) begin
      gap_q <= alu_sum;
    end
  end

  // node tables and tick bookkeeping
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < pllt_pkg::Nodes; i++) begin
        last_seq_q[i] <= '0;
        lost_q[i]     <= '0;
        seen_q[i]     <= '0;
        timer_q[i]    <= (i == 0) ? pllt_pkg::AliveReloadRst : '0;
      end
      alive_q    <= pllt_pkg::Nodes'(1);
      prev_q     <= '0;
      idx_q      <= '0;
      lost_acc_q <= '0;
    end else begin
      unique case (state_q)
        StLoss: begin
          lost_q[addr]     <= lost_new;
          last_seq_q[addr] <= seq_q;
          timer_q[addr]    <= reload_q;
          alive_q[addr]    <= (reload_q != '0);
        end
        StSeen: seen_q[addr] <= alu_sum;
        StElapsed: begin
          idx_q      <= '0;
          lost_acc_q <= '0;
          if (prev_q == '0) begin
            prev_q <= now_q;
          end
        end
        StWalk: begin
          if (!skip_self) begin
            timer_q[addr] <= timer_new;
            alive_q[addr] <= (timer_new != '0);
            if (!alu_carry && timer_rd != '0) begin
              lost_acc_q <= lost_acc_q | lost_bit;
            end
          end
          idx_q <= idx_q + 1'b1;
          if (last_idx) begin
            prev_q <= now_q;
          end
        end
        default: ;
      endcase
    end
  end

  // result registers, loaded as the sequencer returns to idle
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      done_q      <= 1'b0;
      lost_mask_q <= '0;
      loss_out_q  <= '0;
      recv_out_q  <= '0;
    end else begin
      done_q <= (state_q != StIdle) && (state_d == StIdle);
      if ((state_q == StGap && !node_ok) ||
          (state_q == StElapsed && prev_q == '0)) begin
        lost_mask_q <= '0;
        loss_out_q  <= '0;
        recv_out_q  <= '0;
      end else if (state_q == StSeen) begin
        lost_mask_q <= '0;
        loss_out_q  <= lost_q[addr];
        recv_out_q  <= alu_sum;
      end else if (state_q == StWalk && last_idx) begin
        lost_mask_q <= (!skip_self && !alu_carry && timer_rd != '0)
                     ? (lost_acc_q | lost_bit) : lost_acc_q;
        loss_out_q  <= '0;
        recv_out_q  <= '0;
      end
    end
  end

  for (genvar g = 0; g < pllt_pkg::MaskW; g++) begin : g_alive
    if (g < pllt_pkg::Nodes) begin : g_on
      assign alive_mask_o[g] = alive_q[g];
    end else begin : g_off
      assign alive_mask_o[g] = 1'b0;
    end
  end

  assign done_o          = done_q;
  assign lost_mask_o     = lost_mask_q;
  assign loss_count_o    = loss_out_q;
  assign receive_count_o = recv_out_q;

  `include "peer_liveness_loss_tracker_assert.svh"

  // a result only appears once the sequencer is back at idle
  `PLLT_ASSERT_IMP(a_done_idle, done_o, !busy_o, "result while busy")
  // an accepted item always occupies the sequencer
  `PLLT_ASSERT_NXT(a_accept_busy, start_i && !busy_o, busy_o, "accept without busy")
  // a node just declared lost cannot be alive in the same result
  `PLLT_ASSERT_IMP(a_lost_dead, done_o, (lost_mask_o & alive_mask_o) == '0,
                   "lost node shown alive")
  // packet fields stay zero on a tick that lost nodes
  `PLLT_ASSERT_IMP(a_tick_clean, done_o && lost_mask_o != '0,
                   loss_count_o == '0 && receive_count_o == '0, "tick with packet fields")

endmodule

// ----- tb/sv/peer_liveness_loss_tracker_test.sv -----
// Self-checking testbench for peer_liveness_loss_tracker: directed table, then random phases.
// Depends on pllt_pkg and the peer_liveness_loss_tracker RTL; reads no files.
`timescale 1ns / 1ps

module peer_liveness_loss_tracker_test;

  // Opcode of the operation field
  typedef enum logic {
    OpTick   = 1'b0,
    OpPacket = 1'b1
  } op_e;

  // One command item as presented on the start/busy channel
  typedef struct packed {
    op_e                        op;
    logic [pllt_pkg::IdW-1:0]   node;
    logic [pllt_pkg::WordW-1:0] seq;
    logic [pllt_pkg::WordW-1:0] now;
  } event_t;

  // One result item as strobed by done_o
  typedef struct packed {
    logic [pllt_pkg::MaskW-1:0] alive;
    logic [pllt_pkg::MaskW-1:0] lost;
    logic [pllt_pkg::WordW-1:0] loss;
    logic [pllt_pkg::WordW-1:0] recv;
  } report_t;

  // Directed row: typed rows carry their own expectation, the rest use the predictor
  typedef struct packed {
    event_t  ev;
    bit      typed;
    report_t rep;
  } row_t;

  // Worst item is a tick walking every node; a little slack on top
  localparam int          SettleCycles = 3 + pllt_pkg::Nodes + 4;
  localparam int unsigned RunLimit     = 100000;
  localparam int          PhaseItems   = 150;
  localparam int          Phases       = 5;
  localparam int          DirectedRows = 25;

  // Directed stimulus. Rows after reset are typed in; everything depending on
  // gap arithmetic or aging goes through the predictor.
  localparam row_t DirectedPlan [DirectedRows] = '{
    // first tick after reset: nothing aged, node 0 alive from its reset timer
    '{'{OpTick,   3'd0, 32'h0000_0000, 32'd0},     1'b1, '{8'h01, 8'h00, 32'd0, 32'd0}},
    // tick at time zero left previous time at zero: still no aging
    '{'{OpTick,   3'd5, 32'hFFFF_FFFF, 32'd100},   1'b1, '{8'h01, 8'h00, 32'd0, 32'd0}},
    // packets with no stored sequence: no gap taken
    '{'{OpPacket, 3'd0, 32'h0000_0000, 32'd0},     1'b1, '{8'h01, 8'h00, 32'd0, 32'd1}},
    '{'{OpPacket, 3'd7, 32'hFFFF_FFFF, 32'hFFFF_FFFF}, 1'b1, '{8'h81, 8'h00, 32'd0, 32'd1}},
    // sequence wraps from all ones to zero: zero gap
    '{'{OpPacket, 3'd7, 32'h0000_0000, 32'd0},     1'b0, '0},
    // stored zero again: gap skipped
    '{'{OpPacket, 3'd7, 32'h0000_0000, 32'd0},     1'b0, '0},
    // gap of four, then a repeat clears the count
    '{'{OpPacket, 3'd3, 32'h0000_0005, 32'd0},     1'b0, '0},
    '{'{OpPacket, 3'd3, 32'h0000_000A, 32'd0},     1'b0, '0},
    '{'{OpPacket, 3'd3, 32'h0000_000A, 32'd0},     1'b0, '0},
    // largest positive gaps drive the count into saturation and keep it there
    '{'{OpPacket, 3'd3, 32'h8000_000A, 32'd0},     1'b0, '0},
    '{'{OpPacket, 3'd3, 32'h0000_000A, 32'd0},     1'b0, '0},
    '{'{OpPacket, 3'd3, 32'h8000_000A, 32'd0},     1'b0, '0},
    '{'{OpPacket, 3'd3, 32'h8000_000C, 32'd0},     1'b0, '0},
    // gap of exactly 2^31 reads as negative: clear
    '{'{OpPacket, 3'd3, 32'h0000_000D, 32'd0},     1'b0, '0},
    // age by 1000, then by exactly the remaining timer: reaches zero, not flagged
    '{'{OpTick,   3'd0, 32'd0,         32'd1100},  1'b0, '0},
    '{'{OpTick,   3'd0, 32'd0,         32'd8100},  1'b0, '0},
    '{'{OpPacket, 3'd5, 32'h0000_0001, 32'd0},     1'b0, '0},
    '{'{OpPacket, 3'd1, 32'h0000_0001, 32'd0},     1'b0, '0},
    // one ms past the reload: nodes 1 and 5 drop and get flagged
    '{'{OpTick,   3'd2, 32'd0,         32'd16101}, 1'b0, '0},
    '{'{OpPacket, 3'd2, 32'h0000_0002, 32'd0},     1'b0, '0},
    '{'{OpTick,   3'd0, 32'd0,         32'hFFFF_FF00}, 1'b0, '0},
    '{'{OpPacket, 3'd2, 32'h0000_0003, 32'd0},     1'b0, '0},
    // time wraps across zero
    '{'{OpTick,   3'd0, 32'd0,         32'h0000_0100}, 1'b0, '0},
    // tick at zero ages, then the next tick skips aging
    '{'{OpTick,   3'd0, 32'd0,         32'd0},     1'b0, '0},
    '{'{OpTick,   3'd0, 32'd0,         32'd50},    1'b0, '0}
  };

  logic                          clk_i             = 1'b0;
  logic                          rst_ni            = 1'b0;
  logic                          cfg_we_i          = 1'b0;
  logic [0:0]                    cfg_idx_i         = '0;
  logic [pllt_pkg::CfgW-1:0]     cfg_data_i        = '0;
  logic                          start_i           = 1'b0;
  logic                          busy_o;
  logic                          operation_i       = 1'b0;
  logic [pllt_pkg::IdW-1:0]      node_i            = '0;
  logic [pllt_pkg::WordW-1:0]    sequence_number_i = '0;
  logic [pllt_pkg::WordW-1:0]    now_ms_i          = '0;
  logic                          done_o;
  logic [pllt_pkg::MaskW-1:0]    alive_mask_o;
  logic [pllt_pkg::MaskW-1:0]    lost_mask_o;
  logic [pllt_pkg::WordW-1:0]    loss_count_o;
  logic [pllt_pkg::WordW-1:0]    receive_count_o;

  // Shadow copy of the tracker: per-node tables, previous tick, registers
  logic [pllt_pkg::WordW-1:0]    seq_seen  [pllt_pkg::Nodes];
  logic [pllt_pkg::WordW-1:0]    lost_pkts [pllt_pkg::Nodes];
  logic [pllt_pkg::TimerW-1:0]   alive_ms  [pllt_pkg::Nodes];
  logic [pllt_pkg::WordW-1:0]    rx_count  [pllt_pkg::Nodes];
  logic [pllt_pkg::WordW-1:0]    prev_ms;
  logic [pllt_pkg::SelfW-1:0]    my_node;
  logic [pllt_pkg::TimerW-1:0]   reload_ms;

  report_t             outstanding_reports [$];
  int                  errors      = 0;
  int unsigned         cycle_count = 0;

  peer_liveness_loss_tracker u_dut (
    .clk_i             (clk_i),
    .rst_ni            (rst_ni),
    .cfg_we_i          (cfg_we_i),
    .cfg_idx_i         (cfg_idx_i),
    .cfg_data_i        (cfg_data_i),
    .start_i           (start_i),
    .busy_o            (busy_o),
    .operation_i       (operation_i),
    .node_i            (node_i),
    .sequence_number_i (sequence_number_i),
    .now_ms_i          (now_ms_i),
    .done_o            (done_o),
    .alive_mask_o      (alive_mask_o),
    .lost_mask_o       (lost_mask_o),
    .loss_count_o      (loss_count_o),
    .receive_count_o   (receive_count_o)
  );

  always begin
    #6 clk_i = 1'b1;
    #6 clk_i = 1'b0;
  end

  // Watchdog: generous bound on the whole run
  always @(posedge clk_i) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == RunLimit) begin
      $display("peer_liveness_loss_tracker_test: errors");
      $finish;
    end
  end

  // Advance the shadow tracker by one item and return the result it implies.
  function automatic report_t advance_tracker(event_t ev);
    report_t                    rep;
    logic [pllt_pkg::WordW-1:0] gap;
    logic [pllt_pkg::WordW-1:0] sum;
    logic [pllt_pkg::WordW-1:0] elapsed;
    rep = '0;
    if (ev.op == OpPacket) begin
      // Stored zero means no reference sequence yet
      if (seq_seen[ev.node] != '0) begin
        gap = ev.seq - seq_seen[ev.node] - 32'd1;
        if (gap[pllt_pkg::WordW-1]) begin
          lost_pkts[ev.node] = '0;   // repeat or older sequence: peer restarted
        end else begin
          sum = lost_pkts[ev.node] + gap;
          lost_pkts[ev.node] = (sum < gap) ? '1 : sum;
        end
      end
      seq_seen[ev.node] = ev.seq;
      alive_ms[ev.node] = reload_ms;
      rx_count[ev.node] = rx_count[ev.node] + 32'd1;
      rep.loss = lost_pkts[ev.node];
      rep.recv = rx_count[ev.node];
    end else begin
      if (prev_ms != '0) begin
        elapsed = ev.now - prev_ms;
        for (int i = 0; i < pllt_pkg::Nodes; i++) begin
          if (i != int'(my_node)) begin
            // Landing exactly on zero is a decrement, not a loss
            if ({16'd0, alive_ms[i]} < elapsed) begin
              if (alive_ms[i] != '0) rep.lost[i] = 1'b1;
              alive_ms[i] = '0;
            end else begin
              alive_ms[i] = alive_ms[i] - elapsed[pllt_pkg::TimerW-1:0];
            end
          end
        end
      end
      prev_ms = ev.now;
    end
    for (int i = 0; i < pllt_pkg::Nodes; i++) rep.alive[i] = (alive_ms[i] != '0);
    return rep;
  endfunction

  // Random item shaped by the shadow state: mostly in-order packets and
  // ticks paced against the reload, with some raw noise mixed in.
  function automatic event_t random_event();
    event_t      ev;
    int unsigned pick;
    int unsigned step;
    ev.op   = OpTick;
    ev.node = pllt_pkg::IdW'($urandom_range(0, pllt_pkg::Nodes - 1));
    ev.seq  = $urandom;
    ev.now  = $urandom;
    pick    = $urandom_range(0, 99);
    if (pick < 45) begin
      ev.op = OpPacket;
      if ($urandom_range(0, 9) == 0)
        ev.seq = seq_seen[ev.node] - $urandom_range(0, 2);
      else
        ev.seq = seq_seen[ev.node] + 32'd1 + $urandom_range(0, 3);
    end else if (pick < 55) begin
      ev.op = OpPacket;
      if ($urandom_range(0, 3) == 0) ev.seq = '0;
    end else if (pick < 92) begin
      if ($urandom_range(0, 3) == 0)
        step = $urandom_range(0, 2 * int'(reload_ms));
      else
        step = $urandom_range(0, int'(reload_ms) / 4 + 1);
      ev.now = prev_ms + step;
    end else if ($urandom_range(0, 1) == 0) begin
      ev.now = '0;
    end
    return ev;
  endfunction

  // Present one item and return at the edge that takes it.
  task automatic issue(event_t ev, bit typed, report_t typed_rep);
    report_t rep;
    start_i           <= 1'b1;
    operation_i       <= ev.op;
    node_i            <= ev.node;
    sequence_number_i <= ev.seq;
    now_ms_i          <= ev.now;
    do @(posedge clk_i); while (busy_o);
    rep = advance_tracker(ev);
    outstanding_reports.push_back(typed ? typed_rep : rep);
  endtask

  // Sender idling after a take: none, a short burst under busy, or a burst
  // once the block has gone idle, so gaps land on every phase of the work.
  task automatic sender_pause(bit allowed);
    int unsigned mode;
    mode = allowed ? $urandom_range(0, 5) : 0;
    if (mode == 1 || mode == 2) begin
      start_i <= 1'b0;
      repeat ($urandom_range(1, 3)) @(posedge clk_i);
    end else if (mode == 3) begin
      start_i <= 1'b0;
      do @(posedge clk_i); while (busy_o);
      repeat ($urandom_range(1, 3)) @(posedge clk_i);
    end
  endtask

  // Register write while idle: drain, let the last tick walk finish, write.
  task automatic write_reg(pllt_pkg::cfg_idx_e idx, logic [pllt_pkg::CfgW-1:0] value);
    while (outstanding_reports.size() != 0) @(posedge clk_i);
    repeat (SettleCycles) @(posedge clk_i);
    cfg_we_i   <= 1'b1;
    cfg_idx_i  <= idx;
    cfg_data_i <= value;
    @(posedge clk_i);
    cfg_we_i   <= 1'b0;
    if (idx == pllt_pkg::CfgSelfNode) my_node = value[pllt_pkg::SelfW-1:0];
    else                              reload_ms = value[pllt_pkg::TimerW-1:0];
  endtask

  task automatic check_field(string what, logic [pllt_pkg::WordW-1:0] want,
                             logic [pllt_pkg::WordW-1:0] got);
    if (want !== got) begin
      errors++;
      $display("%0t ns: %s expected %h actual %h", $time, what, want, got);
    end
  endtask

  // Results are strobed for one cycle; take each against the oldest expectation
  always @(posedge clk_i) begin : watch_results
    report_t want;
    if (rst_ni && done_o) begin
      if (outstanding_reports.size() == 0) begin
        errors++;
        $display("%0t ns: result expected none actual %h/%h/%h/%h", $time,
                 alive_mask_o, lost_mask_o, loss_count_o, receive_count_o);
      end else begin
        want = outstanding_reports.pop_front();
        check_field("alive_mask", pllt_pkg::WordW'(want.alive),
                    pllt_pkg::WordW'(alive_mask_o));
        check_field("lost_mask", pllt_pkg::WordW'(want.lost),
                    pllt_pkg::WordW'(lost_mask_o));
        check_field("loss_count", want.loss, loss_count_o);
        check_field("receive_count", want.recv, receive_count_o);
      end
    end
  end

  initial begin : stimulus
    logic [pllt_pkg::SelfW-1:0]  next_self;
    logic [pllt_pkg::TimerW-1:0] next_reload;
    // Shadow state starts at the reset values
    for (int i = 0; i < pllt_pkg::Nodes; i++) begin
      seq_seen[i]  = '0;
      lost_pkts[i] = '0;
      alive_ms[i]  = '0;
      rx_count[i]  = '0;
    end
    my_node            = pllt_pkg::SelfNodeRst;
    reload_ms          = pllt_pkg::AliveReloadRst;
    alive_ms[pllt_pkg::SelfNodeRst] = pllt_pkg::AliveReloadRst;
    prev_ms            = '0;

    repeat (8) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    for (int r = 0; r < DirectedRows; r++) begin
      issue(DirectedPlan[r].ev, DirectedPlan[r].typed, DirectedPlan[r].rep);
      sender_pause(1'b1);
    end
    start_i <= 1'b0;

    // Register settings per phase: extremes first, then mid and random values.
    // A new self node keeps whatever its timer held.
    for (int ph = 0; ph < Phases; ph++) begin
      case (ph)
        0: begin
          next_self   = 3'd7;
          next_reload = 16'd1;
        end
        1: begin
          next_self   = 3'd0;
          next_reload = 16'hFFFF;
        end
        2: begin
          next_self   = 3'd3;
          next_reload = 16'd100;
        end
        default: begin
          next_self   = pllt_pkg::SelfW'($urandom_range(0, pllt_pkg::Nodes - 1));
          next_reload = pllt_pkg::TimerW'($urandom_range(1, 65535));
        end
      endcase
      write_reg(pllt_pkg::CfgSelfNode, pllt_pkg::CfgW'(next_self));
      write_reg(pllt_pkg::CfgAliveReload, next_reload);
      @(posedge clk_i);
      for (int n = 0; n < PhaseItems; n++) begin
        issue(random_event(), 1'b0, '0);
        sender_pause(ph != Phases - 1);   // final phase runs back to back
      end
      start_i <= 1'b0;
    end

    while (outstanding_reports.size() != 0) @(posedge clk_i);
    repeat (SettleCycles) @(posedge clk_i);
    if (errors == 0) begin
      $display("peer_liveness_loss_tracker_test: clean");
    end else begin
      $display("peer_liveness_loss_tracker_test: errors");
    end
    $finish;
  end

endmodule
